>>> rtl/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    // Pool geometry
    localparam int NUM_BLOCKS = 256;
    localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int BN_W       = 16;
    localparam int CNT_W      = 13;
    localparam int OP_W       = 2;
    localparam int ST_W       = 2;

    typedef logic [NUM_BLOCKS-1:0] t_map;
    typedef logic [BLK_W-1:0]      t_blk_idx;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FAULT   = 2'd2,
        ST_NOMEM   = 2'd3
    } t_status;

    // Request as held in the input register
    typedef struct packed {
        t_op              op;
        logic [BN_W-1:0]  block_number;
    } t_req;

    // Result as produced by the engine
    typedef struct packed {
        logic [BN_W-1:0]  result_block;
        t_status          status;
        logic [CNT_W-1:0] blocks_in_use;
    } t_result;

endpackage

>>> rtl/bitmap_block_allocator.sv
`timescale 1ns / 1ps
// Bitmap first-fit block allocator.
// Input channel: i_valid / o_stall carry one request (i_op, i_block_number).
// Output channel: o_valid / i_stall carry one result per request
// (o_result_block, o_status, o_blocks_in_use).
// A request goes into an input register, is decoded against the used-block
// bitmap combinationally and lands in the output register when that register
// is free (empty or being read), which raises o_valid. One request per cycle
// is sustained while the receiver does not stall;
// the lowest free block is found by a single priority encoder over the map.
// While the receiver stalls, the result stays in the output register and
// one more request is held in the input register; o_stall rises only when
// both are full.
// Reset (synchronous, active low) empties both registers, marks only the
// null block (block 0) used and sets the use count to one. No clearing
// pass is needed: the map is in flip-flops.
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [OP_W-1:0]  i_op,
    input  logic [BN_W-1:0]  i_block_number,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [BN_W-1:0]  o_result_block,
    output logic [ST_W-1:0]  o_status,
    output logic [CNT_W-1:0] o_blocks_in_use
);

    logic    r_in_valid;
    t_req    r_req;
    logic    r_out_valid;
    t_result r_res;
    t_result res;
    logic    advance;

    // Move the held request on when the output register frees up
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_req.op           <= t_op'(i_op);
            r_req.block_number <= i_block_number;
        end
    end

    bba_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_req   (r_req),
        .o_res   (res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_block  = r_res.result_block;
    assign o_status        = r_res.status;
    assign o_blocks_in_use = r_res.blocks_in_use;

    // Stall upstream only when both registers hold a request
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("stall raised with a free register");

    // Null block is always counted and the count never exceeds the pool
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_blocks_in_use != '0) &&
                    (o_blocks_in_use <= CNT_W'(NUM_BLOCKS)))
        else $error("block count out of range");

    // Invalid requests and failed allocs point at the null block
    a_null_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_NOMEM || o_status == ST_INVALID)
        |-> (o_result_block == '0))
        else $error("rejected request returned a non-null block");

    // A successful alloc never hands out the null block
    a_alloc_nonnull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_req.op == OP_ALLOC) && (res.status == ST_OK)
        |-> (res.result_block != '0))
        else $error("alloc returned the null block");

endmodule

>>> rtl/bba_find_free.sv
`timescale 1ns / 1ps

module bba_find_free
    import bba_pkg::*;
(
    input  t_map     i_map,
    output logic     o_found,
    output t_blk_idx o_index
);

    t_map free_bits;
    t_map lowest;

    // Isolate the lowest clear bit of the map
    assign free_bits = ~i_map;
    assign lowest    = free_bits & (~free_bits + t_map'(1));
    assign o_found   = |free_bits;

    // Encode the one-hot lowest bit into a block index
    always_comb begin
        o_index = '0;
        for (int b = 0; b < BLK_W; b++) begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                if (((i >> b) & 1) == 1) begin
                    o_index[b] = o_index[b] | lowest[i];
                end
            end
        end
    end

endmodule

>>> rtl/bba_engine.sv
`timescale 1ns / 1ps

module bba_engine
    import bba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_req    i_req,
    output t_result o_res
);

    t_map             r_map;
    t_map             n_map;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic     found;
    t_blk_idx free_idx;
    t_blk_idx req_idx;
    logic     num_valid;

    bba_find_free u_find_free (
        .i_map   (r_map),
        .o_found (found),
        .o_index (free_idx)
    );

    // Check the requested block number against the pool
    assign num_valid = (i_req.block_number != '0) &&
                       (i_req.block_number < BN_W'(NUM_BLOCKS));
    assign req_idx   = i_req.block_number[BLK_W-1:0];

    // Decode the request and form the next state
    always_comb begin
        n_map               = r_map;
        n_count             = r_count;
        o_res.result_block  = '0;
        o_res.status        = ST_OK;
        case (i_req.op)
            OP_ALLOC: begin
                if ((r_count != CNT_W'(NUM_BLOCKS)) && found) begin
                    n_map[free_idx]    = 1'b1;
                    n_count            = r_count + CNT_W'(1);
                    o_res.result_block = BN_W'(free_idx);
                end else begin
                    o_res.status = ST_NOMEM;
                end
            end
            OP_FREE: begin
                if (!num_valid) begin
                    o_res.status = ST_INVALID;
                end else if (r_count == CNT_W'(1)) begin
                    o_res.status = ST_FAULT;
                end else if (!r_map[req_idx]) begin
                    o_res.status = ST_FAULT;
                end else begin
                    n_map[req_idx] = 1'b0;
                    n_count        = r_count - CNT_W'(1);
                end
            end
            default: begin
                if (!num_valid) begin
                    o_res.status = ST_INVALID;
                end else if (!r_map[req_idx]) begin
                    o_res.status = ST_FAULT;
                end else begin
                    o_res.result_block = i_req.block_number;
                end
            end
        endcase
        o_res.blocks_in_use = n_count;
    end

    // Commit the update when the request moves to the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= t_map'(1);
            r_count <= CNT_W'(1);
        end else if (i_fire) begin
            r_map   <= n_map;
            r_count <= n_count;
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bba_pkg::*;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int NO_GAP_REQUESTS = 200;
    localparam int CYCLE_LIMIT     = 300000;

    // One row of the directed table; want_* only counts where typed is set
    typedef struct packed {
        t_op              op;
        logic [BN_W-1:0]  bn;
        bit               typed;
        logic [BN_W-1:0]  want_block;
        t_status          want_status;
        logic [CNT_W-1:0] want_count;
    } t_dir_row;

    localparam int DIR_ROWS = 23;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_valid        = 1'b0;
    logic [OP_W-1:0]  i_op           = '0;
    logic [BN_W-1:0]  i_block_number = '0;
    logic             i_stall        = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [BN_W-1:0]  o_result_block;
    logic [ST_W-1:0]  o_status;
    logic [CNT_W-1:0] o_blocks_in_use;

    // Shadow copy of the allocator state
    t_map             used_blocks;
    logic [CNT_W-1:0] blocks_used;

    t_result pending_results[$];
    int      fail_count  = 0;
    int      cycle_count = 0;
    int      burst_left  = 0;
    bit      gaps_on     = 1'b0;
    int      stall_left  = 0;
    int      stall_pct   = 0;

    t_dir_row directed_rows [DIR_ROWS] = '{
        '{OP_READ,  16'd0,     1'b1, 16'd0, ST_INVALID, 13'd1},
        '{OP_FREE,  16'd0,     1'b1, 16'd0, ST_INVALID, 13'd1},
        '{OP_FREE,  16'd5,     1'b1, 16'd0, ST_FAULT,   13'd1},
        '{OP_WRITE, 16'd255,   1'b1, 16'd0, ST_FAULT,   13'd1},
        '{OP_READ,  16'd256,   1'b1, 16'd0, ST_INVALID, 13'd1},
        '{OP_WRITE, 16'd65535, 1'b1, 16'd0, ST_INVALID, 13'd1},
        '{OP_FREE,  16'd65535, 1'b1, 16'd0, ST_INVALID, 13'd1},
        '{OP_ALLOC, 16'd65535, 1'b1, 16'd1, ST_OK,      13'd2},
        '{OP_ALLOC, 16'd0,     1'b1, 16'd2, ST_OK,      13'd3},
        '{OP_READ,  16'd1,     1'b1, 16'd1, ST_OK,      13'd3},
        '{OP_WRITE, 16'd2,     1'b1, 16'd2, ST_OK,      13'd3},
        '{OP_FREE,  16'd1,     1'b1, 16'd0, ST_OK,      13'd2},
        '{OP_FREE,  16'd1,     1'b1, 16'd0, ST_FAULT,   13'd2},
        '{OP_READ,  16'd1,     1'b1, 16'd0, ST_FAULT,   13'd2},
        '{OP_ALLOC, 16'd43690, 1'b0, 16'd0, ST_OK,      13'd0},
        '{OP_FREE,  16'd256,   1'b1, 16'd0, ST_INVALID, 13'd3},
        '{OP_FREE,  16'd255,   1'b1, 16'd0, ST_FAULT,   13'd3},
        '{OP_WRITE, 16'd32768, 1'b1, 16'd0, ST_INVALID, 13'd3},
        '{OP_READ,  16'd2,     1'b0, 16'd0, ST_OK,      13'd0},
        '{OP_FREE,  16'd2,     1'b0, 16'd0, ST_OK,      13'd0},
        '{OP_FREE,  16'd1,     1'b0, 16'd0, ST_OK,      13'd0},
        '{OP_FREE,  16'd1,     1'b1, 16'd0, ST_FAULT,   13'd1},
        '{OP_ALLOC, 16'd21845, 1'b0, 16'd0, ST_OK,      13'd0}
    };

    bitmap_block_allocator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_block_number  (i_block_number),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_block  (o_result_block),
        .o_status        (o_status),
        .o_blocks_in_use (o_blocks_in_use)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic bit block_number_ok(input logic [BN_W-1:0] bn);
        return bn != '0 && bn < BN_W'(NUM_BLOCKS);
    endfunction

    // Apply one request to the shadow state and return what the block must answer
    function automatic t_result allocator_predict(input t_op op, input logic [BN_W-1:0] bn);
        t_result calc;
        calc.result_block = '0;
        calc.status       = ST_OK;
        case (op)
            OP_ALLOC: begin
                calc.status = ST_NOMEM;
                if (blocks_used != CNT_W'(NUM_BLOCKS)) begin
                    for (int i = 0; i < NUM_BLOCKS; i++) begin
                        if (!used_blocks[t_blk_idx'(i)]) begin
                            used_blocks[t_blk_idx'(i)] = 1'b1;
                            blocks_used       = blocks_used + CNT_W'(1);
                            calc.result_block = BN_W'(i);
                            calc.status       = ST_OK;
                            break;
                        end
                    end
                end
            end
            OP_FREE: begin
                if (!block_number_ok(bn))
                    calc.status = ST_INVALID;
                else if (blocks_used == CNT_W'(1))
                    calc.status = ST_FAULT;
                else if (!used_blocks[bn[BLK_W-1:0]])
                    calc.status = ST_FAULT;
                else begin
                    used_blocks[bn[BLK_W-1:0]] = 1'b0;
                    blocks_used     = blocks_used - CNT_W'(1);
                end
            end
            default: begin
                if (!block_number_ok(bn))
                    calc.status = ST_INVALID;
                else if (!used_blocks[bn[BLK_W-1:0]])
                    calc.status = ST_FAULT;
                else
                    calc.result_block = bn;
            end
        endcase
        calc.blocks_in_use = blocks_used;
        return calc;
    endfunction

    // Find a valid block number in the wanted state, starting at a random point
    function automatic logic [BN_W-1:0] pick_block(input bit want_used);
        int start;
        int idx;
        start = $urandom_range(1, NUM_BLOCKS - 1);
        for (int k = 0; k < NUM_BLOCKS - 1; k++) begin
            idx = 1 + (start - 1 + k) % (NUM_BLOCKS - 1);
            if (used_blocks[t_blk_idx'(idx)] == want_used)
                return BN_W'(idx);
        end
        return BN_W'(start);
    endfunction

    // Drop valid between bursts
    task automatic pace_sender();
        if (!gaps_on)
            return;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // Hold the request until accepted, then queue its expected result
    task automatic issue_request(input t_op op, input logic [BN_W-1:0] bn,
                                 input bit typed, input t_result want);
        t_result calc;
        i_valid        <= 1'b1;
        i_op           <= op;
        i_block_number <= bn;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        calc = allocator_predict(op, bn);
        pending_results.push_back(typed ? want : calc);
        pace_sender();
    endtask

    // Receiver stall pattern: random stall density, redrawn when stall_left runs out
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 60;
                default: stall_pct = 90;
            endcase
            stall_left = $urandom_range(8, 60);
        end
        stall_left--;
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Check each delivered result against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result block=%0d status=%0d count=%0d",
                                          o_result_block, o_status, o_blocks_in_use));
            end else begin
                want = pending_results.pop_front();
                if (o_result_block !== want.result_block)
                    report_mismatch($sformatf("result_block got %0d want %0d",
                                              o_result_block, want.result_block));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want.status));
                if (o_blocks_in_use !== want.blocks_in_use)
                    report_mismatch($sformatf("blocks_in_use got %0d want %0d",
                                              o_blocks_in_use, want.blocks_in_use));
            end
        end
    end

    initial begin
        t_result     want;
        t_result     none;
        t_op         op;
        logic [BN_W-1:0] bn;
        bit          draining;
        int          pick;

        none        = '0;
        draining    = 1'b0;
        used_blocks = '0;
        used_blocks[0] = 1'b1;
        blocks_used = CNT_W'(1);

        // Hold reset, then release on a clock edge
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: errors, extremes, empty store, reuse of freed blocks
        gaps_on    = 1'b1;
        burst_left = $urandom_range(1, 8);
        for (int r = 0; r < DIR_ROWS; r++) begin
            want.result_block  = directed_rows[r].want_block;
            want.status        = directed_rows[r].want_status;
            want.blocks_in_use = directed_rows[r].want_count;
            issue_request(directed_rows[r].op, directed_rows[r].bn,
                          directed_rows[r].typed, want);
        end

        // Random requests: alternate filling the pool and draining it
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            gaps_on = (n >= NO_GAP_REQUESTS);
            if (!draining && blocks_used == CNT_W'(NUM_BLOCKS) && $urandom_range(0, 3) == 0)
                draining = 1'b1;
            else if (draining && blocks_used == CNT_W'(1) && $urandom_range(0, 3) == 0)
                draining = 1'b0;

            pick = $urandom_range(0, 99);
            bn   = BN_W'($urandom_range(0, 65535));
            if (pick < (draining ? 15 : 60)) begin
                op = OP_ALLOC;
            end else if (pick < (draining ? 65 : 72)) begin
                op = OP_FREE;
                bn = pick_block(1'b1);
            end else if (pick < (draining ? 72 : 76)) begin
                op = OP_FREE;
                bn = pick_block(1'b0);
            end else if (pick < (draining ? 88 : 90)) begin
                op = t_op'($urandom_range(OP_READ, OP_WRITE));
                bn = BN_W'($urandom_range(1, NUM_BLOCKS - 1));
            end else if (pick < 93) begin
                op = t_op'($urandom_range(OP_FREE, OP_WRITE));
                bn = ($urandom_range(0, 1) == 0) ? '0 : BN_W'(NUM_BLOCKS);
            end else begin
                op = t_op'($urandom_range(0, 3));
            end
            issue_request(op, bn, 1'b0, none);
        end

        // Stop sending and let the pipeline drain
        if (i_valid)
            i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
